// ----- sv/sve_pkg.sv -----
// ----------------------------------------------------------------------------
// sve_pkg: shared types and constants of the shadow volume index emitter
// Item, result, configuration and job types; register codes; mesh limits.
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int MAX_FACES    = 65536;
  localparam int MAX_VERTICES = 32768;
  localparam int FACE_AW      = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int IDX_W        = 16;
  localparam int CAP_COUNT    = 6;
  localparam int TRI          = 3;
  localparam int CNT_W        = $clog2(CAP_COUNT + 1);
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_LIGHT_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_W      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd4;

  localparam logic ACT_FACE = 1'b0;
  localparam logic ACT_EDGE = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        face_index;
    logic signed [15:0]      normal_x;
    logic signed [15:0]      normal_y;
    logic signed [15:0]      normal_z;
    logic signed [15:0]      vert_x;
    logic signed [15:0]      vert_y;
    logic signed [15:0]      vert_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic [IDX_W-1:0]        neighbor_face;
  } sve_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             last;
  } sve_result_t;

  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [15:0] light_w;
    logic [IDX_W-1:0]   vertex_count;
  } sve_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             action;
    logic             front;
    logic             face_front;
    logic             nb_front;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } sve_job_t;

endpackage

// ----- sv/sve_ifs.sv -----
// ----------------------------------------------------------------------------
// sve_ifs: valid/ready channels of the shadow volume index emitter
// One interface for input items, one for result items.
// ----------------------------------------------------------------------------
interface sve_item_if;
  import sve_pkg::*;
  logic      valid;
  logic      ready;
  sve_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sve_result_if;
  import sve_pkg::*;
  logic        valid;
  logic        ready;
  sve_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sve_ram.sv -----
// ----------------------------------------------------------------------------
// sve_ram: generic synchronous RAM
// One write port, two read ports with registered data, read-old-data.
// ----------------------------------------------------------------------------
module sve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- sv/sve_pipe.sv -----
// ----------------------------------------------------------------------------
// sve_pipe: facing test pipeline and facing bit store
// Three stages: light-w products, normal products, sum and sign. Face items
// write their facing bit on leaving the last stage; edge items read both
// faces in the middle stage, with forwarding from the writer ahead.
// ----------------------------------------------------------------------------
module sve_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  sve_pkg::sve_item_t in_data,
  input  sve_pkg::sve_cfg_t  cfg,
  output sve_pkg::sve_job_t  job
);
  import sve_pkg::*;

  logic      v1, v2, v3;
  sve_item_t s1, s2, s3;
  logic signed [31:0] pw_x, pw_y, pw_z;
  logic signed [32:0] dx, dy, dz;
  logic signed [48:0] pr_x, pr_y, pr_z;
  logic signed [50:0] sum;
  logic               front;
  logic               we;
  logic               fwd_a, fwd_b, fwd_val;
  logic               rd_a, rd_b;
  logic               s3_face_ok, s3_nb_ok;

  assign dx  = 33'(cfg.light_x) - 33'(pw_x);
  assign dy  = 33'(cfg.light_y) - 33'(pw_y);
  assign dz  = 33'(cfg.light_z) - 33'(pw_z);
  assign sum = 51'(pr_x) + 51'(pr_y) + 51'(pr_z);

  assign s3_face_ok = {1'b0, s3.face_index} < (IDX_W + 1)'(MAX_FACES);
  assign s3_nb_ok   = {1'b0, s3.neighbor_face} < (IDX_W + 1)'(MAX_FACES);
  assign we = adv && v3 && (s3.action == ACT_FACE) && s3_face_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= in_data;
      pw_x    <= 32'(in_data.vert_x) * 32'(cfg.light_w);
      pw_y    <= 32'(in_data.vert_y) * 32'(cfg.light_w);
      pw_z    <= 32'(in_data.vert_z) * 32'(cfg.light_w);
      s2      <= s1;
      pr_x    <= 49'(dx) * 49'(s1.normal_x);
      pr_y    <= 49'(dy) * 49'(s1.normal_y);
      pr_z    <= 49'(dz) * 49'(s1.normal_z);
      s3      <= s2;
      front   <= sum > 51'sd0;
      fwd_a   <= we && (s3.face_index == s2.face_index);
      fwd_b   <= we && (s3.face_index == s2.neighbor_face);
      fwd_val <= front;
    end
  end

  sve_ram #(.WIDTH(1), .DEPTH(MAX_FACES)) u_facing (
    .clk     (clk),
    .we      (we),
    .waddr   (s3.face_index[FACE_AW-1:0]),
    .wdata   (front),
    .re      (adv),
    .raddr_a (s2.face_index[FACE_AW-1:0]),
    .raddr_b (s2.neighbor_face[FACE_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    job.valid      = v3;
    job.action     = s3.action;
    job.front      = front;
    job.face_front = s3_face_ok && (fwd_a ? fwd_val : rd_a);
    job.nb_front   = s3_nb_ok && (fwd_b ? fwd_val : rd_b);
    job.a          = s3.corner_a;
    job.b          = s3.corner_b;
    job.c          = s3.corner_c;
  end

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(fwd_a) |-> $past(we))
    else $error("forward flag set without a write");
  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    adv |=> v2 == $past(v1) && v3 == $past(v2))
    else $error("pipeline stage valid lost or invented");

endmodule

// ----- sv/sve_emit.sv -----
// ----------------------------------------------------------------------------
// sve_emit: index sequencer
// Builds the six cap or side indices of a job and shifts them out one item
// per cycle while the result is ready; the head tap is the output register.
// ----------------------------------------------------------------------------
module sve_emit (
  input  logic               clk,
  input  logic               rst,
  input  sve_pkg::sve_job_t  job,
  input  sve_pkg::sve_cfg_t  cfg,
  output logic               take,
  sve_result_if.source       result
);
  import sve_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx      [CAP_COUNT];
  logic [IDX_W-1:0] idx_next [CAP_COUNT];
  logic             emits;
  logic             is_open;
  logic             beat;
  logic [IDX_W-1:0] p, q, s1, s2;

  assign beat    = result.valid && result.ready;
  assign is_open = job.c >= cfg.vertex_count;

  always_comb begin
    p = job.front ? job.b : job.c;
    q = job.front ? job.c : job.b;
    s1 = job.face_front ? job.a : job.b;
    s2 = job.face_front ? job.b : job.a;
    if (job.action == ACT_FACE) begin
      emits       = 1'b1;
      idx_next[0] = job.a;
      idx_next[1] = p;
      idx_next[2] = q;
      idx_next[TRI] = cfg.vertex_count + job.a;
      idx_next[4] = cfg.vertex_count + q;
      idx_next[5] = cfg.vertex_count + p;
    end else begin
      emits       = is_open || (job.face_front != job.nb_front);
      idx_next[0] = s1;
      idx_next[1] = cfg.vertex_count + s1;
      idx_next[2] = s2;
      idx_next[TRI] = s2;
      idx_next[4] = cfg.vertex_count + s1;
      idx_next[5] = cfg.vertex_count + s2;
    end
  end

  assign take = job.valid &&
                (!emits || cnt == '0 || (cnt == CNT_W'(1) && result.ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take && emits) begin
      cnt <= CNT_W'(CAP_COUNT);
    end else if (beat) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && emits) begin
      for (int i = 0; i < CAP_COUNT; i++) begin
        idx[i] <= idx_next[i];
      end
    end else if (beat) begin
      for (int i = 0; i < CAP_COUNT - 1; i++) begin
        idx[i] <= idx[i + 1];
      end
    end
  end

  assign result.valid             = cnt != '0;
  assign result.data.vertex_index = idx[0];
  assign result.data.last         = cnt == CNT_W'(1);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAP_COUNT))
    else $error("index count out of range");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    take && emits |-> cnt == '0 || (cnt == CNT_W'(1) && beat))
    else $error("job loaded over pending indices");
  a_load_full: assert property (@(posedge clk) disable iff (rst)
    take && emits |=> cnt == CNT_W'(CAP_COUNT) && result.valid)
    else $error("loaded job not presented");

endmodule

// ----- sv/shadow_volume_index_emitter.sv -----
// ----------------------------------------------------------------------------
// shadow_volume_index_emitter: z-fail stencil shadow volume index stream
// Facing test per face item with facing bit store; cap and side indices.
//
//   channel  | role   | moves
//   ---------+--------+-----------------------------------------------
//   item     | sink   | face or edge item, valid/ready
//   result   | source | one vertex index with last flag, valid/ready
//   cfg_*    | write  | light x/y/z/w and vertex count, no wait
//
// An item passes through the facing pipeline, then its six indices leave
// one per cycle while the result is ready, the one-wide result port setting
// the sustained rate. Edge items without a silhouette leave no result.
// Reset clears control state and the configuration registers; the data registers and the facing store are not cleared.
// A stalled result holds the pipeline once its last stage is occupied.
// ----------------------------------------------------------------------------
module shadow_volume_index_emitter (
  input  logic                            clk,
  input  logic                            rst,
  sve_item_if.sink                        item,
  sve_result_if.source                    result,
  input  logic                            cfg_en,
  input  logic [sve_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);
  import sve_pkg::*;

  sve_cfg_t cfg;
  sve_job_t job;
  logic     take;
  logic     adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_LIGHT_X: cfg.light_x <= cfg_data;
        REG_LIGHT_Y: cfg.light_y <= cfg_data;
        REG_LIGHT_Z: cfg.light_z <= cfg_data;
        REG_LIGHT_W: cfg.light_w <= cfg_data;
        REG_VERTEX_COUNT: begin
          if (cfg_data > IDX_W'(MAX_VERTICES)) begin
            cfg.vertex_count <= IDX_W'(MAX_VERTICES);
          end else begin
            cfg.vertex_count <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  assign adv        = !job.valid || take;
  assign item.ready = adv;

  sve_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (item.valid),
    .in_data  (item.data),
    .cfg      (cfg),
    .job      (job)
  );

  sve_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .job    (job),
    .cfg    (cfg),
    .take   (take),
    .result (result)
  );

endmodule
